### rtl/pfenc_pkg.sv
// Shared types, codes and helper functions for the Playfair digraph encrypter.
// No dependencies; imported by every module under rtl/.
package pfenc_pkg;

   // Item kinds on the request channel, also used as command opcodes
   localparam logic [2:0] KIND_CLEAR  = 3'd0;
   localparam logic [2:0] KIND_KEY    = 3'd1;
   localparam logic [2:0] KIND_FINISH = 3'd2;
   localparam logic [2:0] KIND_TEXT   = 3'd3;
   localparam logic [2:0] KIND_EOT    = 3'd4;

   // Letter indices, A = 0
   localparam logic [4:0] LETTER_I    = 5'd8;
   localparam logic [4:0] LETTER_J    = 5'd9;
   localparam logic [4:0] LETTER_X    = 5'd23;
   localparam logic [4:0] LETTER_LAST = 5'd25;
   localparam int         NUM_LETTERS = 26;
   localparam int         NUM_CELLS   = 25;
   localparam logic [4:0] CELLS_FULL  = 5'd25;
   localparam logic [6:0] ASCII_A     = 7'd65;

   // Command queue between front and back
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;

   typedef struct packed {
      logic [2:0] op;
      logic [4:0] letter;
   } cmd_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
   endfunction

   // Letter index with J folded into I; meaningless for non-letters
   function automatic logic [4:0] letter_of(input logic [7:0] c);
      logic [7:0] v;
      v = (c >= 8'd97) ? c - 8'd97 : c - 8'd65;
      if (v[4:0] == LETTER_J)
         return LETTER_I;
      return v[4:0];
   endfunction

   function automatic logic [2:0] cell_row(input logic [4:0] p);
      if (p >= 5'd20) return 3'd4;
      if (p >= 5'd15) return 3'd3;
      if (p >= 5'd10) return 3'd2;
      if (p >= 5'd5)  return 3'd1;
      return 3'd0;
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] p);
      logic [2:0] r;
      logic [4:0] d;
      r = cell_row(p);
      d = p - ({2'b00, r} << 2) - {2'b00, r};
      return d[2:0];
   endfunction

   function automatic logic [2:0] wrap_inc(input logic [2:0] v);
      return (v == 3'd4) ? 3'd0 : v + 3'd1;
   endfunction

   function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
      return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
   endfunction

endpackage

### rtl/pfenc_front.sv
// Front end: takes request beats, maps bytes to letter indices and drops
// items that have no effect. Depends on pfenc_pkg.
module pfenc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_kind,
   input  logic [7:0]        req_char_code,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output pfenc_pkg::cmd_type cmd
);
   import pfenc_pkg::*;

   logic    cmd_valid_ff, cmd_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    keep;
   logic    accept;

   assign req_ready = !cmd_valid_ff || cmd_ready;
   assign accept    = req_valid && req_ready;
   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      cmd_in.op     = req_kind;
      cmd_in.letter = letter_of(req_char_code);
      unique case (req_kind)
         KIND_CLEAR, KIND_FINISH, KIND_EOT: keep = 1'b1;
         KIND_KEY, KIND_TEXT:               keep = is_letter(req_char_code);
         default:                           keep = 1'b0;
      endcase
      cmd_valid_in = accept ? keep : (cmd_valid_ff && !cmd_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

### rtl/pfenc_fifo.sv
// Two-entry command queue between front and back end.
// Depends on pfenc_pkg.
module pfenc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pfenc_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output pfenc_pkg::cmd_type pop_cmd
);
   import pfenc_pkg::*;

   cmd_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_W:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = count_ff != (FIFO_PTR_W+1)'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/pfenc_back.sv
// Back end: key square build, text pairing and digraph encryption.
// Holds the square and letter position memories. Depends on pfenc_pkg.
module pfenc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  pfenc_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_cipher_letter,
   output logic              rsp_last
);
   import pfenc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILL = 3'd1;
   localparam logic [2:0] ST_POS  = 3'd2;
   localparam logic [2:0] ST_SQ   = 3'd3;
   localparam logic [2:0] ST_OUT0 = 3'd4;
   localparam logic [2:0] ST_OUT1 = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [NUM_LETTERS-1:0] used_ff, used_in;
   logic [4:0]             fill_ff, fill_in;
   logic                   key_ready_ff, key_ready_in;
   logic [4:0]             pend_ff, pend_in;
   logic                   has_pend_ff, has_pend_in;
   logic [4:0]             prev_ff, prev_in;
   logic                   has_prev_ff, has_prev_in;
   logic [4:0]             idx_ff, idx_in;
   logic [4:0]             a_ff, a_in;
   logic [4:0]             b_ff, b_in;

   logic [4:0] square_ff     [NUM_CELLS];
   logic [4:0] letter_pos_ff [NUM_LETTERS];
   logic [4:0] pa_ff, pb_ff;
   logic [4:0] x_ff, y_ff;

   logic       wr_en;
   logic [4:0] wr_letter;
   logic [4:0] addr_x, addr_y;
   logic [2:0] ra, ca, rb, cb;
   logic       pop;
   logic       dbl;

   assign cmd_ready = state_ff == ST_IDLE;
   assign pop       = cmd_valid && cmd_ready;
   assign dbl       = has_prev_ff && prev_ff == cmd.letter;

   assign rsp_valid         = state_ff == ST_OUT0 || state_ff == ST_OUT1;
   assign rsp_last          = state_ff == ST_OUT1;
   assign rsp_cipher_letter = ASCII_A + {2'b00, (state_ff == ST_OUT1) ? y_ff : x_ff};

   // Cipher cells from the two positions
   always_comb begin
      ra = cell_row(pa_ff);
      ca = cell_col(pa_ff);
      rb = cell_row(pb_ff);
      cb = cell_col(pb_ff);
      if (ra == rb) begin
         addr_x = cell_at(ra, wrap_inc(ca));
         addr_y = cell_at(rb, wrap_inc(cb));
      end else if (ca == cb) begin
         addr_x = cell_at(wrap_inc(ra), ca);
         addr_y = cell_at(wrap_inc(rb), cb);
      end else begin
         addr_x = cell_at(ra, cb);
         addr_y = cell_at(rb, ca);
      end
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      fill_in      = fill_ff;
      key_ready_in = key_ready_ff;
      pend_in      = pend_ff;
      has_pend_in  = has_pend_ff;
      prev_in      = prev_ff;
      has_prev_in  = has_prev_ff;
      idx_in       = idx_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      wr_en        = 1'b0;
      wr_letter    = cmd.letter;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (cmd.op)
                  KIND_CLEAR: begin
                     used_in      = '0;
                     fill_in      = '0;
                     key_ready_in = 1'b0;
                     has_pend_in  = 1'b0;
                     has_prev_in  = 1'b0;
                  end
                  KIND_KEY: begin
                     if (!key_ready_ff && fill_ff != CELLS_FULL && !used_ff[cmd.letter]) begin
                        wr_en                = 1'b1;
                        used_in[cmd.letter]  = 1'b1;
                        fill_in              = fill_ff + 5'd1;
                     end
                  end
                  KIND_FINISH: begin
                     if (!key_ready_ff) begin
                        idx_in   = '0;
                        state_in = ST_FILL;
                     end
                  end
                  KIND_TEXT: begin
                     if (key_ready_ff) begin
                        prev_in     = cmd.letter;
                        has_prev_in = 1'b1;
                        if (dbl) begin
                           // doubled letter: an X goes in between
                           state_in = ST_POS;
                           if (has_pend_ff) begin
                              a_in    = pend_ff;
                              b_in    = LETTER_X;
                              pend_in = cmd.letter;
                           end else begin
                              a_in = LETTER_X;
                              b_in = cmd.letter;
                           end
                        end else if (has_pend_ff) begin
                           a_in        = pend_ff;
                           b_in        = cmd.letter;
                           has_pend_in = 1'b0;
                           state_in    = ST_POS;
                        end else begin
                           pend_in     = cmd.letter;
                           has_pend_in = 1'b1;
                        end
                     end
                  end
                  KIND_EOT: begin
                     if (key_ready_ff) begin
                        if (has_pend_ff) begin
                           a_in     = pend_ff;
                           b_in     = LETTER_X;
                           state_in = ST_POS;
                        end
                        has_pend_in = 1'b0;
                        has_prev_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            wr_letter = idx_ff;
            if (idx_ff != LETTER_J && fill_ff != CELLS_FULL && !used_ff[idx_ff]) begin
               wr_en           = 1'b1;
               used_in[idx_ff] = 1'b1;
               fill_in         = fill_ff + 5'd1;
            end
            idx_in = idx_ff + 5'd1;
            if (idx_ff == LETTER_LAST) begin
               key_ready_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_POS:  state_in = ST_SQ;
         ST_SQ:   state_in = ST_OUT0;
         ST_OUT0: if (rsp_ready) state_in = ST_OUT1;
         ST_OUT1: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         fill_ff      <= '0;
         key_ready_ff <= 1'b0;
         has_pend_ff  <= 1'b0;
         has_prev_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         key_ready_ff <= key_ready_in;
         has_pend_ff  <= has_pend_in;
         has_prev_ff  <= has_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      prev_ff <= prev_in;
      idx_ff  <= idx_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
   end

   // Square and position memories: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         square_ff[fill_ff]       <= wr_letter;
         letter_pos_ff[wr_letter] <= fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_POS) begin
         pa_ff <= letter_pos_ff[a_ff];
         pb_ff <= letter_pos_ff[b_ff];
      end
      if (state_ff == ST_SQ) begin
         x_ff <= square_ff[addr_x];
         y_ff <= square_ff[addr_y];
      end
   end

endmodule

### rtl/playfair_digraph_encrypt.sv
// Top level of the Playfair digraph encrypter: front end, command queue, back end.
// Depends on pfenc_pkg, pfenc_front, pfenc_fifo and pfenc_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   req     | req_valid/req_ready  | req_kind[2:0], req_char_code[7:0]
//   rsp     | rsp_valid/rsp_ready  | rsp_cipher_letter[6:0], rsp_last
//
// A key byte, clear, text letter that opens a pair or end of text without an
// open pair is handled in the idle state. A completed pair passes position
// lookup, square lookup and two result beats; finishing the key fills the
// rest of the square in letter order. The back end handles one item at a
// time; the front register and two-entry queue keep accepting beats, until
// they fill, while it works or while rsp is stalled. Reset is synchronous
// and clears the key and text state; the square needs no clearing pass.
module playfair_digraph_encrypt (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_cipher_letter,
   output logic       rsp_last
);
   import pfenc_pkg::*;

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   pfenc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_char_code (req_char_code),
      .cmd_valid     (f_valid),
      .cmd_ready     (f_ready),
      .cmd           (f_cmd)
   );

   pfenc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_cmd    (q_cmd)
   );

   pfenc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (q_valid),
      .cmd_ready         (q_ready),
      .cmd               (q_cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cipher_letter (rsp_cipher_letter),
      .rsp_last          (rsp_last)
   );

endmodule
